// File: rtl/core/key_press_duration_toggler_core_assert.svh
// Assertion macros used by the core scanner module.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef KEY_PRESS_DURATION_TOGGLER_CORE_ASSERT_SVH
`define KEY_PRESS_DURATION_TOGGLER_CORE_ASSERT_SVH

// Same-cycle implication
`define KPDT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define KPDT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/kpdt_pkg.sv
package kpdt_pkg;

    // Widths
    localparam int HOLD_COUNT_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CMP_BITS        =
        (HOLD_COUNT_BITS > CFG_DATA_BITS) ? HOLD_COUNT_BITS : CFG_DATA_BITS;

    // Saturation value of the hold counter
    localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = {HOLD_COUNT_BITS{1'b1}};

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_TICKS  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VLONG_TICKS = CFG_INDEX_BITS'(1);

    // Reset values of the thresholds
    localparam logic [CFG_DATA_BITS-1:0] LONG_TICKS_RST  = CFG_DATA_BITS'(1000);
    localparam logic [CFG_DATA_BITS-1:0] VLONG_TICKS_RST = CFG_DATA_BITS'(3000);

    // Key level meaning
    localparam logic KEY_PRESSED = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HOLD    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_VLONG = 2'd3
    } press_ev_t;

    // Threshold set handed from the register bank to the scanner
    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] long_ticks;
        logic [CFG_DATA_BITS-1:0] vlong_ticks;
    } thresh_t;

    // Word held in the input register
    typedef struct packed {
        logic valid;
        logic level;
    } stage_t;

endpackage

// File: rtl/core/kpdt_key_if.sv
interface kpdt_key_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink   (input valid, input key_level, output ready);
endinterface

// File: rtl/core/kpdt_result_if.sv
interface kpdt_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] press_event;
    logic       lamp_on;
    logic       fan_on;
    logic       spray_on;

    modport source (output valid, output press_event, output lamp_on,
                    output fan_on, output spray_on, input ready);
    modport sink   (input valid, input press_event, input lamp_on,
                    input fan_on, input spray_on, output ready);
endinterface

// File: rtl/core/kpdt_cfg_if.sv
interface kpdt_cfg_if;
    import kpdt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/key_press_duration_toggler_core.sv
// Channel  | Dir | Word
// ---------+-----+-----------------------------------------------
// key      | in  | key_level (0 pressed, 1 released)
// result   | out | press_event, lamp_on, fan_on, spray_on
// cfg      | in  | index, data (0 long, 1 very long threshold)
//
// One key word per cycle sustained while the result channel is ready.
// Path: input register, scanner logic, result register holding the state.
// Reset clears phase, counter and outputs; thresholds return to 1000 and 3000.
// A stalled result holds its word; one more key word is still taken meanwhile.
// Configuration writes are always ready and take effect the next cycle.
module key_press_duration_toggler_core (
    input  logic          clk,
    input  logic          rst_n,
    kpdt_key_if.sink      key,
    kpdt_result_if.source result,
    kpdt_cfg_if.sink      cfg
);
    import kpdt_pkg::*;

    stage_t  word;
    thresh_t thresh;
    logic    take;

    // Threshold registers
    kpdt_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .thresh (thresh)
    );

    // Input register
    kpdt_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key),
        .take  (take),
        .word  (word)
    );

    // Scanner and result register
    kpdt_scanner u_scanner (
        .clk    (clk),
        .rst_n  (rst_n),
        .word   (word),
        .take   (take),
        .thresh (thresh),
        .result (result)
    );

endmodule

// File: rtl/core/kpdt_cfg_regs.sv
module kpdt_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    kpdt_cfg_if.sink         cfg,
    output kpdt_pkg::thresh_t thresh
);
    import kpdt_pkg::*;

    logic [CFG_DATA_BITS-1:0] long_reg, long_next;
    logic [CFG_DATA_BITS-1:0] vlong_reg, vlong_next;

    // Writes are always taken; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_comb
    begin
        long_next  = long_reg;
        vlong_next = vlong_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LONG_TICKS:  long_next  = cfg.data;
                CFG_VLONG_TICKS: vlong_next = cfg.data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg  <= LONG_TICKS_RST;
            vlong_reg <= VLONG_TICKS_RST;
        end
        else
        begin
            long_reg  <= long_next;
            vlong_reg <= vlong_next;
        end
    end

    assign thresh.long_ticks  = long_reg;
    assign thresh.vlong_ticks = vlong_reg;

endmodule

// File: rtl/core/kpdt_in_stage.sv
module kpdt_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    kpdt_key_if.sink         key,
    input  logic             take,
    output kpdt_pkg::stage_t word
);
    import kpdt_pkg::*;

    logic valid_reg, valid_next;
    logic level_reg;
    logic accept;

    // Room when empty or when the held word leaves this cycle
    assign key.ready = !valid_reg || take;
    assign accept    = key.valid && key.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            level_reg <= key.key_level;
    end

    assign word.valid = valid_reg;
    assign word.level = level_reg;

endmodule

// File: rtl/core/kpdt_scanner.sv
module kpdt_scanner (
    input  logic              clk,
    input  logic              rst_n,
    input  kpdt_pkg::stage_t  word,
    output logic              take,
    input  kpdt_pkg::thresh_t thresh,
    kpdt_result_if.source     result
);
    import kpdt_pkg::*;

    `include "key_press_duration_toggler_core_assert.svh"

    phase_t                     phase_reg, phase_next;
    logic [HOLD_COUNT_BITS-1:0] held_ticks_reg, held_ticks_next;
    press_ev_t                  ev_reg, ev_next;
    logic                       lamp_reg, lamp_next;
    logic                       fan_reg, fan_next;
    logic                       spray_reg, spray_next;
    logic                       out_valid_reg, out_valid_next;

    logic                pressed;
    logic [CMP_BITS-1:0] held_cmp, long_cmp, vlong_cmp;

    // Advance when a word is held and the result register is free
    assign take    = word.valid && (!out_valid_reg || result.ready);
    assign pressed = (word.level == KEY_PRESSED);

    assign held_cmp  = CMP_BITS'(held_ticks_reg);
    assign long_cmp  = CMP_BITS'(thresh.long_ticks);
    assign vlong_cmp = CMP_BITS'(thresh.vlong_ticks);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_CONFIRM: phase_next = pressed ? PH_HOLD : PH_IDLE;
                PH_HOLD:    phase_next = pressed ? PH_HOLD : PH_IDLE;
                default:    phase_next = pressed ? PH_CONFIRM : PH_IDLE;
            endcase
        end
    end

    // Counter, event and output toggles
    always_comb
    begin
        held_ticks_next = held_ticks_reg;
        ev_next         = EV_NONE;
        case (phase_reg)
            PH_CONFIRM: ;
            PH_HOLD:
            begin
                if (pressed)
                begin
                    if (held_ticks_reg != HOLD_MAX)
                        held_ticks_next = held_ticks_reg + 1'b1;
                end
                else if (held_cmp >= vlong_cmp)
                    ev_next = EV_VLONG;
                else if (held_cmp >= long_cmp)
                    ev_next = EV_LONG;
                else
                    ev_next = EV_SHORT;
            end
            default:
            begin
                if (pressed)
                    held_ticks_next = '0;
            end
        endcase
        if (!take)
        begin
            held_ticks_next = held_ticks_reg;
            ev_next         = ev_reg;
        end
        lamp_next  = lamp_reg  ^ (take && ev_next == EV_SHORT);
        fan_next   = fan_reg   ^ (take && ev_next == EV_LONG);
        spray_next = spray_reg ^ (take && ev_next == EV_VLONG);
    end

    // Result register valid
    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_ticks_reg <= '0;
            ev_reg         <= EV_NONE;
            lamp_reg       <= 1'b0;
            fan_reg        <= 1'b0;
            spray_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_ticks_reg <= held_ticks_next;
            ev_reg         <= ev_next;
            lamp_reg       <= lamp_next;
            fan_reg        <= fan_next;
            spray_reg      <= spray_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result word comes straight from the state registers
    assign result.valid       = out_valid_reg;
    assign result.press_event = ev_reg;
    assign result.lamp_on     = lamp_reg;
    assign result.fan_on      = fan_reg;
    assign result.spray_on    = spray_reg;

    // Checks
    `KPDT_ASSERT_NXT(a_event_ends_press, take && ev_next != EV_NONE, phase_reg == PH_IDLE, "event without return to idle")
    `KPDT_ASSERT_IMP(a_confirm_count_clear, phase_reg == PH_CONFIRM, held_ticks_reg == '0, "count not cleared at press start")
    `KPDT_ASSERT_NXT(a_stall_holds_state, !take, $stable(held_ticks_reg) && $stable(phase_reg) && $stable(lamp_reg), "state moved without a word")
    `KPDT_ASSERT_NXT(a_short_toggles_lamp, take && ev_next == EV_SHORT, lamp_reg != $past(lamp_reg) && fan_reg == $past(fan_reg), "short press toggle wrong")

endmodule
